// ----- hdl/tcma_pkg.sv -----
// Shared types and fixed widths for the three-channel moving average.
// No dependencies; used by tcma_div and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tcma_pkg;

  localparam int MEAN_W    = 12;
  localparam int TICK_W    = 32;
  localparam int CHANNELS  = 3;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ----- hdl/tcma_window.sv -----
// Sample window of one channel: a row of taps that grows, then slides.
// Depends on nothing; instantiated once per channel by the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcma_window #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 12,
  parameter int CNT_W       = 4,
  parameter int IDX_W       = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic                   sample_ok,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [CNT_W-1:0]       fill,
  input  wire logic [IDX_W-1:0]       rd_idx,
  output logic      [SAMPLE_BITS-1:0] rd_data
);

  logic [SAMPLE_BITS-1:0] taps_r [WINDOW];
  logic                   full;

  assign full    = (fill == CNT_W'(WINDOW));
  assign rd_data = taps_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        taps_r[i] <= '0;
      end
    end else if (wr_en) begin
      if (full) begin
        // Slide toward the oldest end; a failed conversion leaves the
        // previous newest sample repeated in the top slot.
        for (int i = 0; i < WINDOW - 1; i++) begin
          taps_r[i] <= taps_r[i+1];
        end
        if (sample_ok) begin
          taps_r[WINDOW-1] <= sample;
        end
      end else if (sample_ok) begin
        taps_r[fill[IDX_W-1:0]] <= sample;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tcma_div.sv -----
// Shared restoring divider: three sums by one fill count, one quotient bit
// per cycle for every channel. Depends on tcma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcma_div #(
  parameter int SAMPLE_BITS = 12,
  parameter int CNT_W       = 4,
  parameter int SUM_W       = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [SUM_W-1:0]        dividend [tcma_pkg::CHANNELS],
  input  wire logic [CNT_W-1:0]        divisor,
  output tcma_pkg::div_status_t        status,
  output logic      [SAMPLE_BITS-1:0]  quotient [tcma_pkg::CHANNELS]
);

  localparam int STEP_W = $clog2(SAMPLE_BITS + 1);

  logic [STEP_W-1:0]      step_r;
  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       rem_r  [tcma_pkg::CHANNELS];
  logic [SAMPLE_BITS-1:0] quo_r  [tcma_pkg::CHANNELS];
  logic [CNT_W:0]         trial  [tcma_pkg::CHANNELS];
  logic                   fits   [tcma_pkg::CHANNELS];

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

  always_comb begin
    for (int c = 0; c < tcma_pkg::CHANNELS; c++) begin
      trial[c] = {rem_r[c], quo_r[c][SAMPLE_BITS-1]};
      fits[c]  = (trial[c] >= {1'b0, divisor});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SAMPLE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The mean never exceeds the largest sample, so the upper sum bits are
  // already below the divisor and only SAMPLE_BITS steps are needed.
  always_ff @(posedge clk) begin
    for (int c = 0; c < tcma_pkg::CHANNELS; c++) begin
      if (start) begin
        rem_r[c] <= dividend[c][SUM_W-1:SAMPLE_BITS];
        quo_r[c] <= dividend[c][SAMPLE_BITS-1:0];
      end else if (busy_r) begin
        if (fits[c]) begin
          rem_r[c] <= CNT_W'(trial[c] - {1'b0, divisor});
        end else begin
          rem_r[c] <= trial[c][CNT_W-1:0];
        end
        quo_r[c] <= {quo_r[c][SAMPLE_BITS-2:0], fits[c]};
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/three_channel_moving_average.sv -----
// Top level of the three-channel moving average: windows, summing sequencer
// and output register. Depends on tcma_pkg, tcma_window and tcma_div.
//
// Each accepted beat updates the three sample windows at once; the block
// then sums the filled slots, one slot a cycle for all three channels, and
// runs the shared divider. A beat thus passes through the accepting cycle,
// the summing walk over the taps, the one-bit-per-cycle divider, the wait
// for the divider to finish and the load of the result once the output
// register is free. A beat with bus_read_busy set updates the windows and
// yields no result; the input is ready again on the next cycle. The result
// sits in an output register, so the next beat is taken while it waits to
// be drained.
`timescale 1ns / 1ps
`default_nettype none

module three_channel_moving_average #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [SAMPLE_BITS-1:0]         in_ext_sample,
  input  wire logic                           in_ext_ok,
  input  wire logic [SAMPLE_BITS-1:0]         in_itemp_sample,
  input  wire logic                           in_itemp_ok,
  input  wire logic [SAMPLE_BITS-1:0]         in_vref_sample,
  input  wire logic                           in_vref_ok,
  input  wire logic                           in_bus_read_busy,
  input  wire logic [tcma_pkg::TICK_W-1:0]    in_tick_ms,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [tcma_pkg::MEAN_W-1:0]    out_ext_mean,
  output logic      [tcma_pkg::MEAN_W-1:0]    out_itemp_mean,
  output logic      [tcma_pkg::MEAN_W-1:0]    out_vref_mean,
  output logic      [tcma_pkg::TICK_W-1:0]    out_stamp_ms
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = SAMPLE_BITS + CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            fill_r, fill_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [SUM_W-1:0]            acc_r   [tcma_pkg::CHANNELS];
  logic [SUM_W-1:0]            acc_nxt [tcma_pkg::CHANNELS];
  logic [tcma_pkg::TICK_W-1:0] tick_r;
  logic                        out_valid_r;
  logic [tcma_pkg::MEAN_W-1:0] mean_r  [tcma_pkg::CHANNELS];
  logic [tcma_pkg::TICK_W-1:0] stamp_r;

  logic                        accept;
  logic                        last_slot;
  logic                        div_start;
  logic                        out_free;
  logic [SAMPLE_BITS-1:0]      rd_data [tcma_pkg::CHANNELS];
  logic [SAMPLE_BITS-1:0]      quot    [tcma_pkg::CHANNELS];
  tcma_pkg::div_status_t       div_status;

  assign in_stall       = (state_r != S_IDLE);
  assign accept         = in_valid && (state_r == S_IDLE);
  assign out_free       = !out_valid_r || !out_stall;
  assign last_slot      = (idx_r == IDX_W'(fill_r - 1'b1));
  assign div_start      = (state_r == S_SUM) && last_slot;

  assign out_valid      = out_valid_r;
  assign out_ext_mean   = mean_r[0];
  assign out_itemp_mean = mean_r[1];
  assign out_vref_mean  = mean_r[2];
  assign out_stamp_ms   = stamp_r;

  tcma_window #(
    .WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W), .IDX_W(IDX_W)
  ) u_ext_window (
    .clk(clk), .rst_n(rst_n), .wr_en(accept), .sample_ok(in_ext_ok),
    .sample(in_ext_sample), .fill(fill_r), .rd_idx(idx_r), .rd_data(rd_data[0])
  );

  tcma_window #(
    .WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W), .IDX_W(IDX_W)
  ) u_itemp_window (
    .clk(clk), .rst_n(rst_n), .wr_en(accept), .sample_ok(in_itemp_ok),
    .sample(in_itemp_sample), .fill(fill_r), .rd_idx(idx_r), .rd_data(rd_data[1])
  );

  tcma_window #(
    .WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W), .IDX_W(IDX_W)
  ) u_vref_window (
    .clk(clk), .rst_n(rst_n), .wr_en(accept), .sample_ok(in_vref_ok),
    .sample(in_vref_sample), .fill(fill_r), .rd_idx(idx_r), .rd_data(rd_data[2])
  );

  tcma_div #(
    .SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W), .SUM_W(SUM_W)
  ) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_nxt),
    .divisor(fill_r), .status(div_status), .quotient(quot)
  );

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    for (int c = 0; c < tcma_pkg::CHANNELS; c++) begin
      acc_nxt[c] = acc_r[c];
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (fill_r != CNT_W'(WINDOW)) begin
            fill_nxt = fill_r + 1'b1;
          end
          idx_nxt = '0;
          for (int c = 0; c < tcma_pkg::CHANNELS; c++) begin
            acc_nxt[c] = '0;
          end
          if (!in_bus_read_busy) begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        // One slot of every channel per cycle; the divider takes the
        // completed sums straight from this adder on the last slot.
        for (int c = 0; c < tcma_pkg::CHANNELS; c++) begin
          acc_nxt[c] = acc_r[c] + SUM_W'(rd_data[c]);
        end
        idx_nxt = idx_r + 1'b1;
        if (last_slot) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (accept) begin
      tick_r <= in_tick_ms;
    end
    if (state_r == S_OUT && out_free) begin
      for (int c = 0; c < tcma_pkg::CHANNELS; c++) begin
        mean_r[c] <= tcma_pkg::MEAN_W'(quot[c]);
      end
      stamp_r <= tick_r;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_three_channel_moving_average.sv -----
// Self-checking testbench for three_channel_moving_average: directed and random ADC beats,
// a scoreboard class that predicts the three window means, random idling on both sides.
// Depends on tcma_pkg and the three_channel_moving_average RTL.
`timescale 1ns / 1ps

module tb_three_channel_moving_average;

  localparam int TAPS       = 10;
  localparam int SAMPLE_W   = 12;
  localparam int CHANS      = tcma_pkg::CHANNELS;
  localparam int MEAN_W     = tcma_pkg::MEAN_W;
  localparam int TICK_W     = tcma_pkg::TICK_W;
  localparam int RANDOM_N   = 500;
  localparam int SETTLE     = 100;
  localparam int LIMIT      = 400000;
  localparam int HOLD_AT    = 2000;
  localparam int HOLD_LEN   = 500;
  localparam int STALL_PCT  = 11;
  localparam int IDLE_PCT   = 11;

  localparam logic [SAMPLE_W-1:0] CODE_MAX = {SAMPLE_W{1'b1}};

  typedef enum int { CH_EXT = 0, CH_ITEMP = 1, CH_VREF = 2 } adc_chan_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ext_sample;
    logic                ext_ok;
    logic [SAMPLE_W-1:0] itemp_sample;
    logic                itemp_ok;
    logic [SAMPLE_W-1:0] vref_sample;
    logic                vref_ok;
    logic                bus_read_busy;
    logic [TICK_W-1:0]   tick_ms;
  } adc_beat_t;

  typedef struct packed {
    logic [MEAN_W-1:0] ext_mean;
    logic [MEAN_W-1:0] itemp_mean;
    logic [MEAN_W-1:0] vref_mean;
    logic [TICK_W-1:0] stamp_ms;
  } mean_result_t;

  class moving_average_board;
    bit [SAMPLE_W-1:0] taps [CHANS][TAPS];
    int unsigned       filled;
    mean_result_t      awaited_means [$];
    int unsigned       mismatches;

    function new();
      foreach (taps[c, i]) taps[c][i] = '0;
      filled     = 0;
      mismatches = 0;
    endfunction

    function bit [MEAN_W-1:0] window_mean(adc_chan_e ch);
      int unsigned total;
      total = 0;
      for (int i = 0; i < filled; i++) total += taps[ch][i];
      return MEAN_W'(total / filled);
    endfunction

    // Updates the windows with one accepted beat; queues the means unless bus_read_busy is set.
    function void take_conversion(adc_beat_t b);
      bit [SAMPLE_W-1:0] fresh [CHANS];
      bit                ok [CHANS];
      mean_result_t      r;
      int unsigned       slot;
      fresh[CH_EXT]   = b.ext_sample;
      fresh[CH_ITEMP] = b.itemp_sample;
      fresh[CH_VREF]  = b.vref_sample;
      ok[CH_EXT]      = b.ext_ok;
      ok[CH_ITEMP]    = b.itemp_ok;
      ok[CH_VREF]     = b.vref_ok;
      if (filled < TAPS) begin
        filled++;
      end else begin
        // Full window slides; the newest slot keeps a copy of the prior newest sample.
        for (int c = 0; c < CHANS; c++)
          for (int i = 0; i < TAPS - 1; i++) taps[c][i] = taps[c][i + 1];
      end
      slot = filled - 1;
      for (int c = 0; c < CHANS; c++)
        if (ok[c]) taps[c][slot] = fresh[c];
      if (b.bus_read_busy) return;
      r.ext_mean   = window_mean(CH_EXT);
      r.itemp_mean = window_mean(CH_ITEMP);
      r.vref_mean  = window_mean(CH_VREF);
      r.stamp_ms   = b.tick_ms;
      awaited_means.push_back(r);
    endfunction

    function void check_published(mean_result_t got);
      mean_result_t want;
      if (awaited_means.size() == 0) begin
        $error("result beat arrived with no expected means pending");
        mismatches++;
        return;
      end
      want = awaited_means.pop_front();
      if (got.ext_mean !== want.ext_mean) begin
        $error("ext_mean: expected %0d, got %0d", want.ext_mean, got.ext_mean);
        mismatches++;
      end
      if (got.itemp_mean !== want.itemp_mean) begin
        $error("itemp_mean: expected %0d, got %0d", want.itemp_mean, got.itemp_mean);
        mismatches++;
      end
      if (got.vref_mean !== want.vref_mean) begin
        $error("vref_mean: expected %0d, got %0d", want.vref_mean, got.vref_mean);
        mismatches++;
      end
      if (got.stamp_ms !== want.stamp_ms) begin
        $error("stamp_ms: expected %0h, got %0h", want.stamp_ms, got.stamp_ms);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_ext_sample;
  logic                in_ext_ok;
  logic [SAMPLE_W-1:0] in_itemp_sample;
  logic                in_itemp_ok;
  logic [SAMPLE_W-1:0] in_vref_sample;
  logic                in_vref_ok;
  logic                in_bus_read_busy;
  logic [TICK_W-1:0]   in_tick_ms;
  logic                out_valid;
  logic                out_stall;
  logic [MEAN_W-1:0]   out_ext_mean;
  logic [MEAN_W-1:0]   out_itemp_mean;
  logic [MEAN_W-1:0]   out_vref_mean;
  logic [TICK_W-1:0]   out_stamp_ms;

  moving_average_board board = new();
  int unsigned         drain_cycle = 0;
  int unsigned         hold_left = 0;
  int unsigned         cycle_count = 0;

  three_channel_moving_average #(
    .WINDOW      (TAPS),
    .SAMPLE_BITS (SAMPLE_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ext_sample    (in_ext_sample),
    .in_ext_ok        (in_ext_ok),
    .in_itemp_sample  (in_itemp_sample),
    .in_itemp_ok      (in_itemp_ok),
    .in_vref_sample   (in_vref_sample),
    .in_vref_ok       (in_vref_ok),
    .in_bus_read_busy (in_bus_read_busy),
    .in_tick_ms       (in_tick_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ext_mean     (out_ext_mean),
    .out_itemp_mean   (out_itemp_mean),
    .out_vref_mean    (out_vref_mean),
    .out_stamp_ms     (out_stamp_ms)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic adc_beat_t conv(logic [SAMPLE_W-1:0] e, logic eo,
                                     logic [SAMPLE_W-1:0] t, logic to,
                                     logic [SAMPLE_W-1:0] v, logic vo,
                                     logic busy, logic [TICK_W-1:0] tick);
    adc_beat_t b;
    b.ext_sample    = e;
    b.ext_ok        = eo;
    b.itemp_sample  = t;
    b.itemp_ok      = to;
    b.vref_sample   = v;
    b.vref_ok       = vo;
    b.bus_read_busy = busy;
    b.tick_ms       = tick;
    return b;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_code();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CODE_MAX;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Holds the beat on the input until the block takes it, then hands it to the scoreboard.
  task automatic offer(input adc_beat_t b, input bit may_idle);
    if (may_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_ext_sample    <= b.ext_sample;
    in_ext_ok        <= b.ext_ok;
    in_itemp_sample  <= b.itemp_sample;
    in_itemp_ok      <= b.itemp_ok;
    in_vref_sample   <= b.vref_sample;
    in_vref_ok       <= b.vref_ok;
    in_bus_read_busy <= b.bus_read_busy;
    in_tick_ms       <= b.tick_ms;
    do @(posedge clk); while (in_stall);
    board.take_conversion(b);
  endtask

  initial begin : feed
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_ext_sample    <= '0;
    in_ext_ok        <= 1'b0;
    in_itemp_sample  <= '0;
    in_itemp_ok      <= 1'b0;
    in_vref_sample   <= '0;
    in_vref_ok       <= 1'b0;
    in_bus_read_busy <= 1'b0;
    in_tick_ms       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Warm-up: a failed conversion leaves a zero slot in the growing window.
    offer(conv('0, 1'b1, '0, 1'b1, '0, 1'b1, 1'b0, '0), 1'b1);
    offer(conv(CODE_MAX, 1'b0, CODE_MAX, 1'b0, CODE_MAX, 1'b0, 1'b0, '1), 1'b1);
    offer(conv(CODE_MAX, 1'b1, CODE_MAX, 1'b1, CODE_MAX, 1'b1, 1'b0, 32'd1), 1'b1);
    offer(conv(12'hAAA, 1'b1, 12'h555, 1'b1, '0, 1'b1, 1'b1, 32'd2), 1'b1);
    offer(conv(12'h555, 1'b1, 12'hAAA, 1'b1, CODE_MAX, 1'b0, 1'b0, 32'd3), 1'b1);
    for (int k = 0; k < 6; k++)
      offer(conv(CODE_MAX, 1'b1, '0, 1'b1, SAMPLE_W'(k * 700), 1'b1, 1'b0,
                 TICK_W'(100 + k)), 1'b1);
    // Full window: failed conversions repeat the prior newest sample.
    offer(conv(SAMPLE_W'(1), 1'b0, SAMPLE_W'(2), 1'b0, SAMPLE_W'(3), 1'b0, 1'b0,
               32'd200), 1'b1);
    offer(conv(SAMPLE_W'(1), 1'b0, SAMPLE_W'(2), 1'b1, SAMPLE_W'(3), 1'b0, 1'b1,
               32'd201), 1'b1);
    for (int k = 0; k < TAPS; k++)
      offer(conv(CODE_MAX, 1'b1, CODE_MAX, 1'b1, CODE_MAX, 1'b1, 1'b0,
                 TICK_W'(32'h8000_0000 + k)), 1'b1);

    for (int n = 0; n < RANDOM_N; n++)
      offer(conv(random_code(), $urandom_range(99) < 85,
                 random_code(), $urandom_range(99) < 85,
                 random_code(), $urandom_range(99) < 85,
                 $urandom_range(99) < 15, $urandom),
            !(n >= 200 && n < 300));
    in_valid <= 1'b0;

    while (board.awaited_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("tb_three_channel_moving_average passed");
    end else begin
      $display("tb_three_channel_moving_average failed");
    end
    $finish;
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off that backs up the block.
  always @(posedge clk) begin : drain
    mean_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.ext_mean   = out_ext_mean;
      got.itemp_mean = out_itemp_mean;
      got.vref_mean  = out_vref_mean;
      got.stamp_ms   = out_stamp_ms;
      board.check_published(got);
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      drain_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (drain_cycle == HOLD_AT) begin
        hold_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else if (drain_cycle >= 6000 && drain_cycle < 8000) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < STALL_PCT);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_three_channel_moving_average failed");
    $finish;
  end

endmodule
